// ===== rtl/tpfe_pkg.sv =====
`default_nettype none

package tpfe_pkg;

    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned BYTE_W    = 2 * DIGIT_W;
    localparam int unsigned TICK_W    = 24;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;

    localparam logic [BYTE_W-1:0] FLAG_PAIR_RESET     = 8'd126;
    localparam logic [BYTE_W-1:0] ESCAPE_PAIR_RESET   = 8'd125;
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RESET = 24'd1000000;
    localparam logic [TICK_W-1:0] TICK_MAX            = {TICK_W{1'b1}};

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_FLAG_PAIR     = 2'd0,
        REG_ESCAPE_PAIR   = 2'd1,
        REG_TIMEOUT_TICKS = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_idx;

    typedef enum logic {
        CMD_TONE = 1'b0,
        CMD_TICK = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_DATA  = 2'd1,
        EV_START = 2'd2,
        EV_END   = 2'd3
    } t_event;

endpackage

`default_nettype wire

// ===== rtl/tpfe_if.sv =====
`default_nettype none

interface tpfe_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [tpfe_pkg::DIGIT_W-1:0] tone_digit;

    modport source (output valid, output command, output tone_digit, input ready);
    modport sink   (input valid, input command, input tone_digit, output ready);
endinterface

interface tpfe_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  event_res;
    logic [tpfe_pkg::BYTE_W-1:0] data_byte;
    logic                        timed_out;

    modport source (output valid, output event_res, output data_byte, output timed_out,
                    input ready);
    modport sink   (input valid, input event_res, input data_byte, input timed_out,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/tone_pair_flag_escape_deframer_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake      Payload
// i_in      in         valid/ready    command[0], tone_digit[3:0]
// o_out     out        valid/ready    event_res[1:0], data_byte[7:0], timed_out
// apb       in         psel/penable   paddr[3:0], pwdata[31:0] -> prdata[31:0]
//
// Two register stages: an input register and a result register, with the
// deframing logic between them. One item is taken per cycle unless a stall on
// o_out holds a tone; a tone moves through both, a tick yields no result.
// Synchronous active-low reset clears the control state and the config
// registers to their defaults. A stall on o_out holds the result register;
// the input register still drains ticks and accepts one more item behind it.

module tone_pair_flag_escape_deframer_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    tpfe_in_if.sink                              i_in,
    tpfe_out_if.source                           o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tpfe_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [tpfe_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [tpfe_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import tpfe_pkg::*;

    // configuration
    logic [BYTE_W-1:0] r_flag_pair;
    logic [BYTE_W-1:0] r_escape_pair;
    logic [TICK_W-1:0] r_timeout_ticks;
    t_reg_idx          w_reg_idx;

    // input stage
    logic               r_in_valid;
    t_command           r_in_cmd;
    logic [DIGIT_W-1:0] r_in_digit;

    // deframer state
    logic               r_listening,  n_listening;
    logic               r_escaped,    n_escaped;
    logic               r_half_pair,  n_half_pair;
    logic [DIGIT_W-1:0] r_first_digit, n_first_digit;
    logic [TICK_W-1:0]  r_elapsed,    n_elapsed;

    // result stage
    logic              r_out_valid;
    t_event            r_event,  n_event;
    logic [BYTE_W-1:0] r_byte,   n_byte;
    logic              r_tout,   n_tout;

    logic w_advance;
    logic w_is_tick;
    logic w_listen_eff;
    logic w_half_eff;

    // ---------------- APB register file ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_pair     <= FLAG_PAIR_RESET;
            r_escape_pair   <= ESCAPE_PAIR_RESET;
            r_timeout_ticks <= TIMEOUT_TICKS_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg_idx)
                REG_FLAG_PAIR:     r_flag_pair     <= pwdata[BYTE_W-1:0];
                REG_ESCAPE_PAIR:   r_escape_pair   <= pwdata[BYTE_W-1:0];
                REG_TIMEOUT_TICKS: r_timeout_ticks <= pwdata[TICK_W-1:0];
                default: ;  // write to an unmapped address: drop
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_FLAG_PAIR:     prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, r_flag_pair};
            REG_ESCAPE_PAIR:   prdata = {{(APB_DATA_W-BYTE_W){1'b0}}, r_escape_pair};
            REG_TIMEOUT_TICKS: prdata = {{(APB_DATA_W-TICK_W){1'b0}}, r_timeout_ticks};
            default:           prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    // A tick never needs the result register, so it always advances; a tone
    // advances when the result register is empty or being emptied.
    assign w_is_tick = (r_in_cmd == CMD_TICK);
    assign w_advance = r_in_valid && (w_is_tick || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // Capture payload on every transfer
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cmd   <= t_command'(i_in.command);
            r_in_digit <= i_in.tone_digit;
        end
    end

    // ---------------- deframing logic ----------------
    always_comb begin
        n_listening   = r_listening;
        n_escaped     = r_escaped;
        n_half_pair   = r_half_pair;
        n_first_digit = r_first_digit;
        n_elapsed     = r_elapsed;
        n_event       = EV_NONE;
        n_byte        = '0;
        n_tout        = 1'b0;
        w_listen_eff  = r_listening;
        w_half_eff    = r_half_pair;

        if (w_advance) begin
            if (w_is_tick) begin
                // count silence, saturating
                if (r_elapsed != TICK_MAX) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
            end else begin
                // silence too long: drop the half pair and go back to listening
                if (r_elapsed > r_timeout_ticks) begin
                    n_tout       = 1'b1;
                    w_half_eff   = 1'b0;
                    w_listen_eff = 1'b1;
                end
                n_elapsed   = '0;
                n_listening = w_listen_eff;

                if (!w_half_eff) begin
                    n_first_digit = r_in_digit;
                    n_half_pair   = 1'b1;
                end else begin
                    n_half_pair = 1'b0;
                    n_byte      = {r_first_digit, r_in_digit};
                    if (w_listen_eff) begin
                        // only the start flag matters while listening
                        if (n_byte == r_flag_pair) begin
                            n_listening = 1'b0;
                            n_event     = EV_START;
                        end
                    end else if (r_escaped) begin
                        // literal pair, whatever its value
                        n_escaped = 1'b0;
                        n_event   = EV_DATA;
                    end else if (n_byte == r_escape_pair) begin
                        n_escaped = 1'b1;
                    end else if (n_byte == r_flag_pair) begin
                        n_listening = 1'b1;
                        n_event     = EV_END;
                    end else begin
                        n_event = EV_DATA;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listening   <= 1'b1;
            r_escaped     <= 1'b0;
            r_half_pair   <= 1'b0;
            r_first_digit <= '0;
            r_elapsed     <= '0;
        end else begin
            r_listening   <= n_listening;
            r_escaped     <= n_escaped;
            r_half_pair   <= n_half_pair;
            r_first_digit <= n_first_digit;
            r_elapsed     <= n_elapsed;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && !w_is_tick) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load on a tone; otherwise hold
    always_ff @(posedge i_clk) begin
        if (w_advance && !w_is_tick) begin
            r_event <= n_event;
            r_byte  <= n_byte;
            r_tout  <= n_tout;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.event_res = r_event;
    assign o_out.data_byte = r_byte;
    assign o_out.timed_out = r_tout;

endmodule

`default_nettype wire

// ===== bench/tpfe_bench_pkg.sv =====
`timescale 1ns / 100ps

package tpfe_bench_pkg;

    import tpfe_pkg::*;

    typedef struct {
        t_event            kind;
        logic [BYTE_W-1:0] data_byte;
        logic              timed_out;
    } t_deframe_event;

    // Tracks the deframer state and queues the event each tone should produce.
    class t_deframe_tracker;

        logic [BYTE_W-1:0]  flag_pair;
        logic [BYTE_W-1:0]  escape_pair;
        logic [TICK_W-1:0]  timeout_ticks;

        bit                 listening;
        bit                 escaped;
        bit                 half_pair;
        logic [DIGIT_W-1:0] first_digit;
        logic [TICK_W-1:0]  elapsed_ticks;

        t_deframe_event     awaited[$];
        int unsigned        faults;

        function new();
            flag_pair     = FLAG_PAIR_RESET;
            escape_pair   = ESCAPE_PAIR_RESET;
            timeout_ticks = TIMEOUT_TICKS_RESET;
            listening     = 1'b1;
            escaped       = 1'b0;
            half_pair     = 1'b0;
            first_digit   = '0;
            elapsed_ticks = '0;
            faults        = 0;
        endfunction

        function void load_register(t_reg_idx idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                REG_FLAG_PAIR:     flag_pair     = value[BYTE_W-1:0];
                REG_ESCAPE_PAIR:   escape_pair   = value[BYTE_W-1:0];
                REG_TIMEOUT_TICKS: timeout_ticks = value[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_symbol(t_command cmd, logic [DIGIT_W-1:0] digit);
            t_deframe_event    e;
            logic [BYTE_W-1:0] pair;
            if (cmd == CMD_TICK) begin
                if (elapsed_ticks != TICK_MAX)
                    elapsed_ticks = elapsed_ticks + 1'b1;
                return;
            end
            e.kind      = EV_NONE;
            e.data_byte = '0;
            e.timed_out = 1'b0;
            // silence too long: drop the half pair, fall back to hunting for a flag
            if (elapsed_ticks > timeout_ticks) begin
                e.timed_out = 1'b1;
                half_pair   = 1'b0;
                listening   = 1'b1;
            end
            elapsed_ticks = '0;
            if (!half_pair) begin
                first_digit = digit;
                half_pair   = 1'b1;
            end else begin
                half_pair   = 1'b0;
                pair        = {first_digit, digit};
                e.data_byte = pair;
                if (listening) begin
                    if (pair == flag_pair) begin
                        listening = 1'b0;
                        e.kind    = EV_START;
                    end
                end else if (escaped) begin
                    escaped = 1'b0;
                    e.kind  = EV_DATA;
                end else if (pair == escape_pair) begin
                    escaped = 1'b1;
                end else if (pair == flag_pair) begin
                    listening = 1'b1;
                    e.kind    = EV_END;
                end else begin
                    e.kind = EV_DATA;
                end
            end
            awaited = {awaited, e};
        endfunction

        function void report_fault(string what);
            faults++;
            if (faults <= 10)
                $display("%s", what);
        endfunction

        function void match_event(logic [1:0] kind, logic [BYTE_W-1:0] data_byte,
                                  logic timed_out);
            t_deframe_event e;
            if (awaited.size() == 0) begin
                report_fault($sformatf("unexpected event: kind=%0d byte=%02h timed_out=%0b",
                                       kind, data_byte, timed_out));
                return;
            end
            e = awaited.pop_front();
            if (e.kind != kind || e.data_byte != data_byte || e.timed_out != timed_out)
                report_fault({
                    $sformatf("event mismatch: expected kind=%0d byte=%02h timed_out=%0b",
                              e.kind, e.data_byte, e.timed_out),
                    $sformatf(", got kind=%0d byte=%02h timed_out=%0b",
                              kind, data_byte, timed_out)});
        endfunction

    endclass

endpackage

// ===== bench/tb_tone_pair_flag_escape_deframer_unit.sv =====
`timescale 1ns / 100ps

module tb_tone_pair_flag_escape_deframer_unit;

    import tpfe_pkg::*;
    import tpfe_bench_pkg::*;

    localparam int unsigned ITEM_TARGET  = 950;
    localparam int unsigned PHASE_ITEMS  = 110;
    // a tone surfaces via the input and result registers; allow for ticks still in flight
    localparam int unsigned DRAIN_CYCLES = 6;
    // longest legitimate quiet stretch is one input gap plus one output stall plus
    // the pipeline
    localparam int unsigned QUIET_LIMIT  = 4000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    tpfe_in_if  in_if ();
    tpfe_out_if out_if ();

    t_deframe_tracker track;

    // idle switches, flipped now and then so that both busy and gappy stretches occur
    bit idle_in  = 1'b1;
    bit idle_out = 1'b1;

    int unsigned items_sent  = 0;
    int unsigned quiet_count = 0;

    // current settings, mirrored here so that the generator can build proper frames
    logic [BYTE_W-1:0] cur_flag    = FLAG_PAIR_RESET;
    logic [BYTE_W-1:0] cur_escape  = ESCAPE_PAIR_RESET;
    logic [TICK_W-1:0] cur_timeout = TIMEOUT_TICKS_RESET;

    tone_pair_flag_escape_deframer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Sample every transfer at the rising edge. Results are checked before the
    // new input is noted; the pipeline latency keeps the two apart anyway.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready)
                track.match_event(out_if.event_res, out_if.data_byte, out_if.timed_out);
            if (in_if.valid && in_if.ready)
                track.take_symbol(t_command'(in_if.command), in_if.tone_digit);
            if (psel && penable && pwrite && pready)
                track.load_register(t_reg_idx'(paddr[3:2]), pwdata);
        end
    end

    // Watchdog: give up once nothing has moved for too long.
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (psel && penable)) begin
            quiet_count <= 0;
        end else begin
            quiet_count <= quiet_count + 1;
            if (quiet_count == QUIET_LIMIT) begin
                $display("tone_pair_flag_escape_deframer_unit regression: fail");
                $finish;
            end
        end
    end

    // Result side: stall a random number of cycles, then take one transfer.
    initial begin
        int unsigned stall;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = idle_out ? $urandom_range(0, 19) : 0;
            if (stall != 0) begin
                out_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
        end
    end

    // Present one item and hold it until the transfer. Called at a falling
    // edge, returns at a falling edge with valid still high, so back-to-back
    // items keep valid up without a glitch.
    task automatic push_item(input t_command cmd, input logic [DIGIT_W-1:0] digit);
        int unsigned gap;
        gap = idle_in ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid      = 1'b1;
        in_if.command    = cmd;
        in_if.tone_digit = digit;
        do @(posedge i_clk); while (!(in_if.valid && in_if.ready));
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic send_tick();
        // the digit is ignored on a tick; randomise it anyway
        push_item(CMD_TICK, DIGIT_W'($urandom_range(0, 15)));
    endtask

    task automatic send_pair(input logic [BYTE_W-1:0] pair);
        push_item(CMD_TONE, pair[7:4]);
        push_item(CMD_TONE, pair[3:0]);
    endtask

    // Hold off input and wait until the block has nothing left in flight.
    task automatic settle();
        in_if.valid = 1'b0;
        while (track.awaited.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Reprogram all registers with the block idle. Upper write bits carry junk
    // so that the masking is exercised; the spare address gets a write too.
    task automatic apply_setting(input logic [BYTE_W-1:0] flag,
                                 input logic [BYTE_W-1:0] escape,
                                 input logic [TICK_W-1:0] timeout);
        logic [APB_DATA_W-1:0] word;
        settle();
        word = $urandom();
        word[BYTE_W-1:0] = flag;
        apb_write(REG_FLAG_PAIR, word);
        word = $urandom();
        word[BYTE_W-1:0] = escape;
        apb_write(REG_ESCAPE_PAIR, word);
        word = $urandom();
        word[TICK_W-1:0] = timeout;
        apb_write(REG_TIMEOUT_TICKS, word);
        apb_write(REG_UNUSED, $urandom());
        cur_flag    = flag;
        cur_escape  = escape;
        cur_timeout = timeout;
    endtask

    // Pick a frame payload byte, biased towards the flag and escape values.
    function automatic logic [BYTE_W-1:0] payload_byte();
        case ($urandom_range(0, 5))
            0:       return cur_flag;
            1:       return cur_escape;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed frames with random content; the rest is noise,
    // broken frames, odd digits that shift the pairing, and runs of ticks.
    task automatic run_traffic(input int unsigned quota);
        int unsigned       stop_at;
        int unsigned       n;
        int unsigned       run;
        logic [BYTE_W-1:0] b;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 19) == 0) begin
                idle_in  = ($urandom_range(0, 2) != 0);
                idle_out = ($urandom_range(0, 2) != 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    send_pair(cur_flag);
                    n = $urandom_range(0, 8);
                    repeat (n) begin
                        b = payload_byte();
                        if (b == cur_flag || b == cur_escape)
                            send_pair(cur_escape);
                        send_pair(b);
                        if ($urandom_range(0, 7) == 0)
                            send_tick();
                    end
                    send_pair(cur_flag);
                end
                6: begin
                    n = $urandom_range(1, 6);
                    repeat (n) push_item(CMD_TONE, DIGIT_W'($urandom_range(0, 15)));
                end
                7: begin
                    // long enough to cross a small timeout now and then
                    run = (cur_timeout < 64) ? $urandom_range(1, cur_timeout + 3)
                                             : $urandom_range(1, 4);
                    repeat (run) send_tick();
                end
                8: begin
                    // frame abandoned part way, possibly with an escape pending
                    send_pair(cur_flag);
                    n = $urandom_range(0, 3);
                    repeat (n) send_pair(payload_byte());
                    if ($urandom_range(0, 1) == 0)
                        send_pair(cur_escape);
                end
                default: push_item(CMD_TONE, DIGIT_W'($urandom_range(0, 15)));
            endcase
        end
    endtask

    initial begin
        int unsigned phase;
        logic [BYTE_W-1:0] b;

        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_if.valid      = 1'b0;
        in_if.command    = CMD_TONE;
        in_if.tone_digit = '0;
        track            = new();

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed, reset settings: stray pair while listening, frame start,
        // escape on its own, escaped flag and escaped escape passed as data,
        // extreme data bytes, frame end.
        send_pair(8'h12);
        send_pair(FLAG_PAIR_RESET);
        send_pair(ESCAPE_PAIR_RESET);
        send_pair(FLAG_PAIR_RESET);
        send_pair(ESCAPE_PAIR_RESET);
        send_pair(ESCAPE_PAIR_RESET);
        send_pair(8'hFF);
        send_pair(8'h00);
        send_pair(FLAG_PAIR_RESET);

        // Directed, timeout of one tick: silence equal to the limit is fine,
        // one more tick times out; the pending escape survives the timeout and
        // applies to the first pair after the next start flag.
        apply_setting(FLAG_PAIR_RESET, ESCAPE_PAIR_RESET, 24'd1);
        send_pair(FLAG_PAIR_RESET);
        send_tick();
        send_pair(ESCAPE_PAIR_RESET);
        send_tick();
        send_tick();
        push_item(CMD_TONE, FLAG_PAIR_RESET[7:4]);
        push_item(CMD_TONE, FLAG_PAIR_RESET[3:0]);
        send_pair(FLAG_PAIR_RESET);
        send_pair(FLAG_PAIR_RESET);

        // Random phases, each under its own setting; extremes come first.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0: apply_setting(8'h00, 8'hFF, 24'd0);
                1: apply_setting(8'hFF, 8'h00, TICK_MAX);
                2: begin
                    // flag equal to escape: the escape test wins inside a frame
                    b = BYTE_W'($urandom_range(0, 255));
                    apply_setting(b, b, 24'd6);
                end
                3: apply_setting(FLAG_PAIR_RESET, ESCAPE_PAIR_RESET, 24'd12);
                default: apply_setting(BYTE_W'($urandom_range(0, 255)),
                                       BYTE_W'($urandom_range(0, 255)),
                                       ($urandom_range(0, 3) == 0) ?
                                           TICK_W'($urandom()) :
                                           TICK_W'($urandom_range(0, 40)));
            endcase
            // trim the last phase so the total stays close to the target
            run_traffic((ITEM_TARGET - items_sent < PHASE_ITEMS) ?
                            (ITEM_TARGET - items_sent) : PHASE_ITEMS);
            phase++;
        end

        // Drain and let any trailing ticks work through before judging.
        settle();
        if (track.faults == 0 && track.awaited.size() == 0) begin
            $display("tone_pair_flag_escape_deframer_unit regression: pass");
        end else begin
            $display("tone_pair_flag_escape_deframer_unit regression: fail");
        end
        $finish;
    end

endmodule

// ===== tone_pair_flag_escape_deframer_unit.f =====
rtl/tpfe_pkg.sv
rtl/tpfe_if.sv
rtl/tone_pair_flag_escape_deframer_unit.sv
bench/tpfe_bench_pkg.sv
bench/tb_tone_pair_flag_escape_deframer_unit.sv
